FILE: rtl/abb_pkg.sv
// Shared types, constants and the divide-by-255 helper for the alpha blit blender.
// No dependencies; used by every module under rtl/ except abb_fifo.
`default_nettype none

package abb_pkg;

  // Configuration register layout
  localparam int unsigned RegW  = 13;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_FB_WIDTH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FB_HEIGHT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BITMAP_WIDTH = 3'd4;

  localparam logic [RegW-1:0] FB_WIDTH_RST     = 13'd640;
  localparam logic [RegW-1:0] FB_HEIGHT_RST    = 13'd480;
  localparam logic [RegW-1:0] ORIGIN_X_RST     = 13'd0;
  localparam logic [RegW-1:0] ORIGIN_Y_RST     = 13'd0;
  localparam logic [RegW-1:0] BITMAP_WIDTH_RST = 13'd1;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned PixW       = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Per-pixel decision made by the front end
  typedef struct packed {
    logic wr;      // pixel lands on screen and is not fully transparent
    logic opaque;  // alpha is 0xFF: source passes through unchanged
  } cls_t;

  // Exact floor(x/255) for x <= 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/alpha_blit_blender.sv
// Top level of the ARGB8888 source-over alpha blit: front end, queue and blend back end.
// Depends on abb_pkg, abb_front, abb_fifo and abb_back.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: src, dst; tlast: end of bitmap
//   m_axis    out        m_axis_tvalid/tready      tdata: x, y, pixel; tuser: write enable
//   cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i (always ready)
//
// One pixel per clock sustained while the output is not stalled; each result passes
// through the queue entry written at the input transfer, then the multiply-accumulate
// stage, then the divide-by-255 output register.
// rst_ni clears counters, queue and pipeline valids and loads default registers.
// Output stalls back up through the pipeline into the queue; the input stalls only when
// the queue is full.
`default_nettype none

module alpha_blit_blender #(
  parameter int unsigned CoordBits = abb_pkg::COORD_BITS,
  localparam int unsigned OutDataW = ((2 * CoordBits + 32 + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [abb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [abb_pkg::RegW-1:0]     cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [63:0]                  s_axis_tdata,  // src_pixel, dst_pixel
  input  wire logic                         s_axis_tlast,  // end_of_bitmap
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [OutDataW-1:0]               m_axis_tdata,  // pixel_x, pixel_y, pixel_value, pad
  output logic                              m_axis_tuser   // write_enable
);

  localparam int unsigned QW = 2 + 2 * CoordBits + 64;

  abb_pkg::cls_t        f_cls, q_cls;
  logic [CoordBits-1:0] f_x, f_y, q_x, q_y, o_x, o_y;
  logic [31:0]          q_src, q_dst, o_pixel;
  logic                 q_valid, q_ready;
  logic [QW-1:0]        q_in, q_out;

  abb_front #(.CoordBits(CoordBits)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .alpha_i     (s_axis_tdata[31:24]),
    .last_i      (s_axis_tlast),
    .cls_o       (f_cls),
    .x_o         (f_x),
    .y_o         (f_y)
  );

  assign q_in = {f_cls, f_x, f_y, s_axis_tdata};

  abb_fifo #(.Width(QW), .Depth(abb_pkg::QueueDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (q_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_out)
  );

  assign {q_cls, q_x, q_y, q_dst, q_src} = q_out;

  abb_back #(.CoordBits(CoordBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_cls_i    (q_cls),
    .in_x_i      (q_x),
    .in_y_i      (q_y),
    .in_src_i    (q_src),
    .in_dst_i    (q_dst),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_we_o    (m_axis_tuser),
    .out_x_o     (o_x),
    .out_y_o     (o_y),
    .out_pixel_o (o_pixel)
  );

  // zero padding up to whole bytes
  assign m_axis_tdata = OutDataW'({o_pixel, o_y, o_x});

endmodule

`default_nettype wire

FILE: rtl/abb_fifo.sv
// Small first-in first-out queue between the classifying front end and the blend back end.
// Depends on nothing; width and depth come from the instantiating module.
`default_nettype none

module abb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abb_front.sv
// Front end: configuration registers, bitmap position counters, target coordinate and clipping.
// Depends on abb_pkg.
`default_nettype none

module abb_front #(
  parameter int unsigned CoordBits = abb_pkg::COORD_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [abb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [abb_pkg::RegW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,   // queue has room
  input  wire logic [7:0]                   alpha_i,
  input  wire logic                         last_i,
  output abb_pkg::cls_t                     cls_o,
  output logic [CoordBits-1:0]              x_o,
  output logic [CoordBits-1:0]              y_o
);

  localparam int unsigned RegW = abb_pkg::RegW;
  localparam int unsigned MaxW = (CoordBits > RegW) ? CoordBits : RegW;
  localparam int unsigned TW   = MaxW + 2;  // signed target coordinate
  localparam int unsigned UW   = TW - 1;    // magnitude once known non-negative

  logic [RegW-1:0]      fb_width_q, fb_height_q, origin_x_q, origin_y_q, bitmap_width_q;
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d, col_inc;
  logic signed [TW-1:0] tx, ty;
  logic                 on_x, on_y, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q     <= abb_pkg::FB_WIDTH_RST;
      fb_height_q    <= abb_pkg::FB_HEIGHT_RST;
      origin_x_q     <= abb_pkg::ORIGIN_X_RST;
      origin_y_q     <= abb_pkg::ORIGIN_Y_RST;
      bitmap_width_q <= abb_pkg::BITMAP_WIDTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        abb_pkg::REG_FB_WIDTH:     fb_width_q     <= cfg_data_i;
        abb_pkg::REG_FB_HEIGHT:    fb_height_q    <= cfg_data_i;
        abb_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_data_i;
        abb_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg_data_i;
        abb_pkg::REG_BITMAP_WIDTH: bitmap_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // origin is 13-bit two's complement, counters unsigned
  assign tx = TW'($signed(origin_x_q)) + $signed(TW'(col_q));
  assign ty = TW'($signed(origin_y_q)) + $signed(TW'(row_q));

  assign on_x = !tx[TW-1] && (tx[UW-1:0] < UW'(fb_width_q))
                && (tx[UW-1:0] <= UW'({CoordBits{1'b1}}));
  assign on_y = !ty[TW-1] && (ty[UW-1:0] < UW'(fb_height_q))
                && (ty[UW-1:0] <= UW'({CoordBits{1'b1}}));

  assign cls_o.wr     = (alpha_i != abb_pkg::ALPHA_CLEAR) && on_x && on_y;
  assign cls_o.opaque = (alpha_i == abb_pkg::ALPHA_OPAQUE);
  assign x_o          = tx[CoordBits-1:0];
  assign y_o          = ty[CoordBits-1:0];

  assign col_inc = col_q + CoordBits'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc == '0 || MaxW'(col_inc) >= MaxW'(bitmap_width_q)) begin
        // row wrap; a zero width behaves as width one
        col_d = '0;
        row_d = row_q + CoordBits'(1);
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abb_back.sv
// Back end: per-channel multiply-accumulate stage, then divide by 255 into the output register.
// Depends on abb_pkg.
`default_nettype none

module abb_back #(
  parameter int unsigned CoordBits = abb_pkg::COORD_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire abb_pkg::cls_t         in_cls_i,
  input  wire logic [CoordBits-1:0]  in_x_i,
  input  wire logic [CoordBits-1:0]  in_y_i,
  input  wire logic [31:0]           in_src_i,
  input  wire logic [31:0]           in_dst_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       out_we_o,
  output logic [CoordBits-1:0]       out_x_o,
  output logic [CoordBits-1:0]       out_y_o,
  output logic [31:0]                out_pixel_o
);

  logic                 s1_valid_q, out_valid_q;
  logic                 en1, en2;
  abb_pkg::cls_t        s1_cls_q;
  logic [CoordBits-1:0] s1_x_q, s1_y_q, out_x_q, out_y_q;
  logic [31:0]          s1_src_q, out_pixel_q, pixel_d;
  logic [15:0]          sum_d [3];
  logic [15:0]          sum_q [3];
  logic                 out_we_q;
  logic [7:0]           alpha, alpha_inv;

  assign en2        = !out_valid_q || out_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  assign alpha     = in_src_i[31:24];
  assign alpha_inv = 8'd255 - alpha;

  // channel 0 blue, 1 green, 2 red
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = 16'(in_src_i[8*c +: 8]) * 16'(alpha)
               + 16'(in_dst_i[8*c +: 8]) * 16'(alpha_inv);
    end
  end

  always_comb begin
    pixel_d = '0;
    if (s1_cls_q.wr) begin
      if (s1_cls_q.opaque) begin
        pixel_d = s1_src_q;
      end else begin
        pixel_d = {abb_pkg::ALPHA_OPAQUE, abb_pkg::div255(sum_q[2]),
                   abb_pkg::div255(sum_q[1]), abb_pkg::div255(sum_q[0])};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_cls_q <= in_cls_i;
      s1_x_q   <= in_x_i;
      s1_y_q   <= in_y_i;
      s1_src_q <= in_src_i;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_d[c];
      end
    end
    if (en2 && s1_valid_q) begin
      out_we_q    <= s1_cls_q.wr;
      out_x_q     <= s1_cls_q.wr ? s1_x_q : '0;
      out_y_q     <= s1_cls_q.wr ? s1_y_q : '0;
      out_pixel_q <= pixel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_we_o    = out_we_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_pixel_o = out_pixel_q;

endmodule

`default_nettype wire

FILE: bench/blit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the alpha blit blender: tracks the config, pixel and write channels,
// predicts every framebuffer write and compares it field by field. Needs abb_pkg only.
module blit_checker #(
  parameter int unsigned OutDataW = ((2 * abb_pkg::COORD_BITS + 32 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [abb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [abb_pkg::RegW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // src_pixel, dst_pixel
  input  logic                        s_axis_tlast,   // end_of_bitmap
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [OutDataW-1:0]         m_axis_tdata,   // pixel_x, pixel_y, pixel_value, pad
  input  logic                        m_axis_tuser,   // write_enable
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  localparam int unsigned CB = abb_pkg::COORD_BITS;
  localparam int CoordMax = (1 << CB) - 1;

  typedef struct packed {
    logic          write_enable;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic [31:0]   pixel_value;
  } blit_write_t;

  blit_write_t expected_writes[$];
  blit_write_t got, want;

  logic [abb_pkg::RegW-1:0]        fb_width_q, fb_height_q, bitmap_width_q;
  logic signed [abb_pkg::RegW-1:0] origin_x_q, origin_y_q;
  logic [CB-1:0]                   col_q, row_q, next_col;

  function automatic bit on_screen(input int c, input int limit);
    return c >= 0 && c < limit && c <= CoordMax;
  endfunction

  function automatic logic [7:0] channel_mix(input int unsigned s, input int unsigned d,
                                             input int unsigned a);
    int unsigned mixed;
    mixed = (s * a + d * (255 - a)) / 255;
    return mixed[7:0];
  endfunction

  // Write produced by one source pixel at the current bitmap cursor
  function automatic blit_write_t blend_at_cursor(input logic [31:0] src,
                                                  input logic [31:0] dst);
    blit_write_t w;
    int tx, ty;
    int unsigned a;
    w = '0;
    a = src[31:24];
    tx = origin_x_q;
    tx = tx + int'(col_q);
    ty = origin_y_q;
    ty = ty + int'(row_q);
    if (src[31:24] != abb_pkg::ALPHA_CLEAR && on_screen(tx, fb_width_q) &&
        on_screen(ty, fb_height_q)) begin
      w.write_enable = 1'b1;
      w.pixel_x = tx[CB-1:0];
      w.pixel_y = ty[CB-1:0];
      if (src[31:24] == abb_pkg::ALPHA_OPAQUE) begin
        w.pixel_value = src;
      end else begin
        w.pixel_value = {abb_pkg::ALPHA_OPAQUE,
                         channel_mix(src[23:16], dst[23:16], a),
                         channel_mix(src[15:8], dst[15:8], a),
                         channel_mix(src[7:0], dst[7:0], a)};
      end
    end
    return w;
  endfunction

  function automatic int unsigned field_mismatch(input string name, input logic [31:0] exp,
                                                 input logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q     = abb_pkg::FB_WIDTH_RST;
      fb_height_q    = abb_pkg::FB_HEIGHT_RST;
      origin_x_q     = abb_pkg::ORIGIN_X_RST;
      origin_y_q     = abb_pkg::ORIGIN_Y_RST;
      bitmap_width_q = abb_pkg::BITMAP_WIDTH_RST;
      col_q          = '0;
      row_q          = '0;
      expected_writes.delete();
      pending_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          abb_pkg::REG_FB_WIDTH:     fb_width_q = cfg_data_i;
          abb_pkg::REG_FB_HEIGHT:    fb_height_q = cfg_data_i;
          abb_pkg::REG_ORIGIN_X:     origin_x_q = cfg_data_i;
          abb_pkg::REG_ORIGIN_Y:     origin_y_q = cfg_data_i;
          abb_pkg::REG_BITMAP_WIDTH: bitmap_width_q = cfg_data_i;
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.write_enable = m_axis_tuser;
        got.pixel_x      = m_axis_tdata[CB-1:0];
        got.pixel_y      = m_axis_tdata[2*CB-1:CB];
        got.pixel_value  = m_axis_tdata[2*CB+31:2*CB];
        if (expected_writes.size() == 0) begin
          $error("write transfer with nothing expected: write_enable %0b value 0x%0h",
                 got.write_enable, got.pixel_value);
          fail_count_o++;
        end else begin
          want = expected_writes.pop_front();
          fail_count_o += field_mismatch("write_enable", want.write_enable, got.write_enable);
          fail_count_o += field_mismatch("pixel_x", want.pixel_x, got.pixel_x);
          fail_count_o += field_mismatch("pixel_y", want.pixel_y, got.pixel_y);
          fail_count_o += field_mismatch("pixel_value", want.pixel_value, got.pixel_value);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        expected_writes.push_back(blend_at_cursor(s_axis_tdata[31:0], s_axis_tdata[63:32]));
        // raster cursor: column wraps at the bitmap width or the counter range
        if (s_axis_tlast) begin
          col_q = '0;
          row_q = '0;
        end else begin
          next_col = col_q + 1'b1;
          if (next_col == '0 || next_col >= bitmap_width_q) begin
            col_q = '0;
            row_q = row_q + 1'b1;
          end else begin
            col_q = next_col;
          end
        end
      end

      pending_o = expected_writes.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the alpha blit blender bench: clock, reset, config writes, pixel stimulus and
// write-side back-pressure. Depends on abb_pkg, alpha_blit_blender and blit_checker.
module testbench;

  localparam int unsigned OutDataW = ((2 * abb_pkg::COORD_BITS + 32 + 7) / 8) * 8;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PixelsPerPhase = 170;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned CalmPhase = 7;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainCycles = 8;
  localparam longint unsigned LimitNs = 5_000_000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [abb_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [abb_pkg::RegW-1:0]    cfg_data_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [63:0]                 s_axis_tdata;
  logic                        s_axis_tlast;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [OutDataW-1:0]         m_axis_tdata;
  logic                        m_axis_tuser;

  int unsigned fail_count, pending;
  bit calm, hold_req;
  logic [abb_pkg::RegW-1:0] cur_bitmap_width;

  alpha_blit_blender u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  blit_checker #(.OutDataW(OutDataW)) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(LimitNs);
    $display("status: fail");
    $finish;
  end

  // Write side: random stalls, none while calm, and one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(0, 99) >= 22;
      end
    end
  end

  task automatic write_reg(input logic [abb_pkg::CfgIdxW-1:0] idx,
                           input logic [abb_pkg::RegW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [abb_pkg::RegW-1:0] fb_w, fb_h, org_x, org_y,
                              bmp_w);
    write_reg(abb_pkg::REG_FB_WIDTH, fb_w);
    write_reg(abb_pkg::REG_FB_HEIGHT, fb_h);
    write_reg(abb_pkg::REG_ORIGIN_X, org_x);
    write_reg(abb_pkg::REG_ORIGIN_Y, org_y);
    write_reg(abb_pkg::REG_BITMAP_WIDTH, bmp_w);
    cfg_valid_i <= 1'b0;
    cur_bitmap_width = bmp_w;
  endtask

  task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst, input bit last);
    s_axis_tdata  <= {dst, src};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (!calm) begin
      while ($urandom_range(0, 99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_src();
    logic [31:0] p;
    p = $urandom();
    case ($urandom_range(0, 4))
      0: p[31:24] = abb_pkg::ALPHA_CLEAR;
      1: p[31:24] = abb_pkg::ALPHA_OPAQUE;
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [abb_pkg::RegW-1:0] pick_size();
    case ($urandom_range(0, 11))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      default: return 13'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [abb_pkg::RegW-1:0] pick_origin();
    int v;
    case ($urandom_range(0, 9))
      0: v = -4096;
      1: v = 4095;
      2: v = -1;
      default: v = int'($urandom_range(0, 48)) - 16;
    endcase
    return v[abb_pkg::RegW-1:0];
  endfunction

  // One bitmap of random content; now and then cut short or left without its end marker
  task automatic send_bitmap(output int unsigned count);
    int unsigned cols, rows;
    bit drop_last;
    if (cur_bitmap_width == 0) cols = 1;
    else if (cur_bitmap_width > 32) cols = $urandom_range(1, 32);
    else cols = cur_bitmap_width;
    rows = $urandom_range(1, 5);
    count = cols * rows;
    drop_last = 1'b0;
    case ($urandom_range(0, 11))
      0: count = $urandom_range(1, count);
      1: drop_last = 1'b1;
      default: ;
    endcase
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_src(), $urandom(), !drop_last && i == count - 1);
    end
  endtask

  initial begin
    int unsigned sent, chunk;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    cur_bitmap_width = abb_pkg::BITMAP_WIDTH_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // transparent, opaque and blended pixels; top byte of dst must not matter
    program_regs(13'd640, 13'd480, 13'd0, 13'd0, 13'd3);
    send_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_pixel(32'hFF00_0000, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h80FF_FFFF, 32'hFF00_0000, 1'b0);
    send_pixel(32'h0100_0000, 32'h00FF_FFFF, 1'b0);
    send_pixel(32'hFE12_3456, 32'hAB65_4321, 1'b1);
    wait_for_drain();

    // framebuffer larger than the coordinate range: x or y of 4096 must clip
    program_regs(13'd8191, 13'd4096, 13'd4095, 13'd4095, 13'd2);
    send_pixel(32'hFFA5_A5A5, 32'h0000_0000, 1'b0);
    send_pixel(32'hFF5A_5A5A, 32'h0000_0000, 1'b0);
    send_pixel(32'h7F00_FF00, 32'h00FF_00FF, 1'b1);
    wait_for_drain();

    // zero-width framebuffer clips everything
    program_regs(13'd0, 13'd8191, 13'h1000, 13'h1FFF, 13'd8191);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h4000_0000, 32'hFFFF_FFFF, 1'b1);
    wait_for_drain();

    // zero bitmap width acts as one column: each pixel starts a row
    program_regs(13'd1, 13'd2, 13'd0, 13'd0, 13'd0);
    send_pixel(32'hFF01_0203, 32'h0000_0000, 1'b0);
    send_pixel(32'hC0FF_8001, 32'h1234_5678, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    wait_for_drain();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      program_regs(pick_size(), pick_size(), pick_origin(), pick_origin(),
                   ($urandom_range(0, 9) == 0) ? 13'd0 :
                   ($urandom_range(0, 8) == 0) ? 13'd8191 : 13'($urandom_range(1, 24)));
      // one phase runs without any stalls on either side
      calm = (phase == CalmPhase);
      if (phase == PressurePhase) hold_req = 1'b1;
      sent = 0;
      while (sent < PixelsPerPhase) begin
        send_bitmap(chunk);
        sent += chunk;
      end
      wait_for_drain();
    end
    calm = 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
